// ===== hw/rtl/spss_pkg.sv =====
// Shared types and constants for the servo PWM step sequencer.
// Used by servo_pwm_step_sequencer; depends on nothing.
`timescale 1ns / 1ps

package spss_pkg;

  localparam int CLK_BITS  = 20;   // timer width of period and widths
  localparam int MAX_STEPS = 16;   // step table depth
  localparam int STEP_W    = 4;    // step index width
  localparam int HOLD_W    = 16;
  localparam int REP_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CLK_BITS-1:0] PERIOD_RESET      = CLK_BITS'(100000);
  localparam logic [CLK_BITS-1:0] START_WIDTH_RESET = CLK_BITS'(12500);

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_FEED  = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_WRITE = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD      = 1'd0,
    REG_START_WIDTH = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    func_t               func;
    logic [REP_W-1:0]    repeat_count;
    logic [STEP_W-1:0]   step_slot;
    logic [CLK_BITS-1:0] step_target;
    logic [CLK_BITS-1:0] step_speed;
    logic [HOLD_W-1:0]   step_hold;
  } in_item_t;

  typedef struct packed {
    logic                pin_level;
    logic                running;
    logic [CLK_BITS-1:0] pulse_width;
    logic [STEP_W-1:0]   step_now;
    logic                feed_accepted;
  } out_item_t;

endpackage

// ===== hw/rtl/servo_pwm_step_sequencer.sv =====
// Servo PWM step sequencer top level: request decode, state update, step table,
// output register with skid stage. Depends on spss_pkg.
`timescale 1ns / 1ps

// Usage
// -----
// in channel  (in_valid/in_ready/in_data): one request per item. func selects
//   timer tick, feed start, stop, or step table write. Each tick advances the
//   PWM phase countdown by one timer clock.
// out channel (out_valid/out_ready/out_data): exactly one result per request:
//   pin level, run flag, current pulse width, step index, feed accepted flag.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready. Write only while idle.
// Each result is registered and presented from the output register.
// Throughput: one request per cycle while the skid stage is empty. The whole state update is a
//   single pass of logic from the state registers back to themselves; the
//   longest path is the slew step (compare, subtract, clamp, add).
// Stall: a result waiting on out_ready does not block the next request; it
//   lands in a one-entry skid stage, and in_ready drops only while that is full.
// Reset (rst, synchronous): run flag off, pin low, width back to the default
//   start width, speed table emptied (per-entry nonzero flags). Target and
//   hold entries are not cleared. A start width write only matters at reset,
//   where the register returns to its default anyway, so it is not stored.
module servo_pwm_step_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  spss_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output spss_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spss_pkg::CLK_BITS-1:0]   cfg_data
);

  localparam int CW = spss_pkg::CLK_BITS;
  localparam int SW = spss_pkg::STEP_W;
  localparam int HW = spss_pkg::HOLD_W;
  localparam int RW = spss_pkg::REP_W;

  // configuration
  logic [CW-1:0] period_clks;

  // step table; speed is qualified by a nonzero flag that reset clears
  logic [CW-1:0] target_table [spss_pkg::MAX_STEPS];
  logic [CW-1:0] speed_table  [spss_pkg::MAX_STEPS];
  logic [HW-1:0] hold_table   [spss_pkg::MAX_STEPS];
  logic [spss_pkg::MAX_STEPS-1:0] speed_nz;

  // sequencer state
  logic [CW-1:0] phase_countdown, phase_countdown_next;
  logic [CW-1:0] next_phase_len, next_phase_len_next;
  logic [CW-1:0] width_now, width_now_next;
  logic [HW-1:0] hold_left, hold_left_next;
  logic [SW-1:0] step_pointer, step_pointer_next;
  logic [RW-1:0] passes_left, passes_left_next;
  logic          run_flag, run_flag_next;
  logic          pin_state, pin_state_next;
  logic          feed_ok;

  // output register and skid stage
  logic                o_valid, s_valid;
  spss_pkg::out_item_t o_data, s_data, result;

  logic in_acc;
  logic tbl_wr;

  assign in_ready  = !s_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = o_valid;
  assign out_data  = o_data;

  // current and following step lookups
  logic [CW-1:0] cur_tgt, cur_spd;
  logic [HW-1:0] cur_hold;
  logic          cur_live, nxt_live;
  logic [SW:0]   sp_inc;

  assign cur_tgt  = target_table[step_pointer];
  assign cur_spd  = speed_table[step_pointer];
  assign cur_hold = hold_table[step_pointer];
  assign cur_live = speed_nz[step_pointer];
  assign sp_inc   = {1'b0, step_pointer} + (SW+1)'(1);
  assign nxt_live = (sp_inc < (SW+1)'(spss_pkg::MAX_STEPS)) && speed_nz[sp_inc[SW-1:0]];

  // slew-limited move toward the current target
  logic          mv_up, mv_clamp, mv_reached;
  logic [CW-1:0] mv_dist, mv_width;

  assign mv_up      = cur_tgt > width_now;
  assign mv_dist    = mv_up ? (cur_tgt - width_now) : (width_now - cur_tgt);
  assign mv_clamp   = mv_dist > cur_spd;
  assign mv_reached = !mv_clamp;
  assign mv_width   = mv_clamp ? (mv_up ? (width_now + cur_spd) : (width_now - cur_spd))
                               : cur_tgt;

  always_comb begin
    logic [RW-1:0] pass_dec;
    logic          end_pass;
    logic [CW-1:0] flip_len;
    logic [HW-1:0] hold_dec;

    phase_countdown_next = phase_countdown;
    next_phase_len_next  = next_phase_len;
    width_now_next       = width_now;
    hold_left_next       = hold_left;
    step_pointer_next    = step_pointer;
    passes_left_next     = passes_left;
    run_flag_next        = run_flag;
    pin_state_next       = pin_state;
    feed_ok              = 1'b0;
    tbl_wr               = 1'b0;
    end_pass             = 1'b0;
    pass_dec             = (passes_left != '0) ? (passes_left - RW'(1)) : passes_left;
    flip_len             = period_clks - next_phase_len;
    hold_dec             = hold_left - HW'(1);

    case (in_data.func)
      spss_pkg::FUNC_TICK: begin
        if (run_flag) begin
          if (phase_countdown > CW'(1)) begin
            phase_countdown_next = phase_countdown - CW'(1);
          end else begin
            phase_countdown_next = next_phase_len;
            pin_state_next       = !pin_state;
            next_phase_len_next  = flip_len;
            if (pin_state) begin
              // falling edge: hold countdown, slew step, or end of pass
              if (hold_left != '0) begin
                hold_left_next = hold_dec;
                if (hold_dec == '0) begin
                  if (nxt_live) begin
                    step_pointer_next = sp_inc[SW-1:0];
                  end else begin
                    end_pass = 1'b1;
                  end
                end
              end else if (!cur_live) begin
                end_pass = 1'b1;
              end else begin
                width_now_next      = mv_width;
                next_phase_len_next = mv_width;
                if (mv_reached) begin
                  hold_left_next = (cur_hold == '0) ? HW'(1) : cur_hold;
                end
              end
            end
          end
        end
      end
      spss_pkg::FUNC_FEED: begin
        if (!run_flag) begin
          step_pointer_next    = '0;
          next_phase_len_next  = width_now;
          hold_left_next       = '0;
          passes_left_next     = (in_data.repeat_count == '0) ? RW'(1)
                                                              : in_data.repeat_count;
          phase_countdown_next = period_clks - width_now;
          run_flag_next        = 1'b1;
          feed_ok              = 1'b1;
        end
      end
      spss_pkg::FUNC_STOP: begin
        run_flag_next = 1'b0;
      end
      spss_pkg::FUNC_WRITE: begin
        tbl_wr = ({1'b0, in_data.step_slot} < (SW+1)'(spss_pkg::MAX_STEPS));
      end
      default: begin
      end
    endcase

    if (end_pass) begin
      passes_left_next = pass_dec;
      if (pass_dec == '0) begin
        run_flag_next = 1'b0;
      end else begin
        step_pointer_next = '0;
      end
    end
  end

  assign result.pin_level     = pin_state_next;
  assign result.running       = run_flag_next;
  assign result.pulse_width   = width_now_next;
  assign result.step_now      = step_pointer_next;
  assign result.feed_accepted = feed_ok;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      period_clks <= spss_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready &&
                 cfg_index == spss_pkg::CFG_IDX_W'(spss_pkg::REG_PERIOD)) begin
      period_clks <= cfg_data;
    end
  end

  // step table payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc && tbl_wr) begin
      target_table[in_data.step_slot] <= in_data.step_target;
      speed_table[in_data.step_slot]  <= in_data.step_speed;
      hold_table[in_data.step_slot]   <= in_data.step_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_nz <= '0;
    end else if (in_acc && tbl_wr) begin
      speed_nz[in_data.step_slot] <= (in_data.step_speed != '0);
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_countdown <= '0;
      next_phase_len  <= '0;
      width_now       <= spss_pkg::START_WIDTH_RESET;
      hold_left       <= '0;
      step_pointer    <= '0;
      passes_left     <= '0;
      run_flag        <= 1'b0;
      pin_state       <= 1'b0;
    end else if (in_acc) begin
      phase_countdown <= phase_countdown_next;
      next_phase_len  <= next_phase_len_next;
      width_now       <= width_now_next;
      hold_left       <= hold_left_next;
      step_pointer    <= step_pointer_next;
      passes_left     <= passes_left_next;
      run_flag        <= run_flag_next;
      pin_state       <= pin_state_next;
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (out_ready || !o_valid) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        o_valid <= in_acc;
      end
    end else if (in_acc) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !o_valid) begin
      if (s_valid) begin
        o_data <= s_data;
      end else if (in_acc) begin
        o_data <= result;
      end
    end else if (in_acc) begin
      s_data <= result;
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid holds a result while the output register is empty");

  a_feed_runs: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_data.feed_accepted) |-> o_data.running)
    else $error("accepted feed reported without running");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.func == spss_pkg::FUNC_STOP) |=> !run_flag)
    else $error("stop request left the sequencer running");

  a_pin_idle: assert property (@(posedge clk) disable iff (rst)
    !run_flag |=> pin_state == $past(pin_state))
    else $error("pin toggled while stopped");

endmodule
